FILE: hw/rtl/rnag_pkg.sv
`default_nettype none

package rnag_pkg;

   // field and register widths
   localparam int FIELD_DIMS       = 4;
   localparam int MAX_DIMS_DEFAULT = 4;
   localparam int INDEX_W          = 16;
   localparam int EXT_W            = 13;
   localparam int DIM_COUNT_W      = 3;
   localparam int ELEM_W           = 9;
   localparam int OFFSET_W         = 56;

   // offset multiplies are split into two halves of the accumulator
   localparam int HALF_W           = OFFSET_W / 2;
   localparam int PROD_W           = HALF_W + EXT_W;

   // remainder unit: digit width and stage counts
   localparam int DIGIT_W          = 4;
   localparam int MOD_STAGES       = INDEX_W / DIGIT_W;
   localparam int LANE_STAGES      = MOD_STAGES + 1;

   // register port
   localparam int ADDR_W           = 5;
   localparam int DATA_W           = 32;

   typedef enum logic [2:0] {
      REG_DIM_COUNT   = 3'd0,
      REG_SIZE_DIM0   = 3'd1,
      REG_SIZE_DIM1   = 3'd2,
      REG_SIZE_DIM2   = 3'd3,
      REG_SIZE_DIM3   = 3'd4,
      REG_ELEM_BYTES  = 3'd5,
      REG_TORUS_MODE  = 3'd6,
      REG_BOUND_CHECK = 3'd7
   } reg_index_type;

   // per-lane settings derived from the registers
   typedef struct packed {
      logic             used;
      logic             torus;
      logic [EXT_W-1:0] extent;
   } lane_cfg_type;

   // what one lane hands to the merge stage
   typedef struct packed {
      logic [INDEX_W-1:0] val;
      logic [EXT_W-1:0]   extent;
      logic               bad;
   } lane_res_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rnag_lane.sv
`default_nettype none

module rnag_lane (
   input  wire logic                                  clock,
   input  wire logic [rnag_pkg::LANE_STAGES-1:0]      stage_en,
   input  wire rnag_pkg::lane_cfg_type                cfg,
   input  wire logic [rnag_pkg::INDEX_W-1:0]          index,
   output rnag_pkg::lane_res_type                     res
);

   localparam int IW = rnag_pkg::INDEX_W;
   localparam int EW = rnag_pkg::EXT_W;
   localparam int DW = rnag_pkg::DIGIT_W;
   localparam int NM = rnag_pkg::MOD_STAGES;

   // one restoring-division digit: shift in DW dividend bits, keep remainder
   function automatic logic [EW-1:0] mod_digit(input logic [EW-1:0] rem,
                                               input logic [DW-1:0] digit,
                                               input logic [EW-1:0] ext);
      logic [EW:0]   t;
      logic [EW-1:0] r;
      r = rem;
      for (int b = DW - 1; b >= 0; b--) begin
         t = {r, digit[b]};
         if (t >= {1'b0, ext}) begin
            r = EW'(t - {1'b0, ext});
         end else begin
            r = t[EW-1:0];
         end
      end
      return r;
   endfunction

   logic [IW-1:0] ix_ff  [NM];
   logic [IW-1:0] ix_in  [NM];
   logic [IW-1:0] mag_ff [NM];
   logic [IW-1:0] mag_in [NM];
   logic [EW-1:0] rem_ff [NM];
   logic [EW-1:0] rem_in [NM];

   // remainder of the index magnitude, DW bits per stage, msb first
   for (genvar j = 0; j < NM; j++) begin : g_div
      if (j == 0) begin : g_first
         assign ix_in[j]  = index;
         assign mag_in[j] = index[IW-1] ? IW'(~index + 1'b1) : index;
         assign rem_in[j] = mod_digit('0, mag_in[j][IW-1 -: DW], cfg.extent);
      end else begin : g_next
         assign ix_in[j]  = ix_ff[j-1];
         assign mag_in[j] = mag_ff[j-1];
         assign rem_in[j] = mod_digit(rem_ff[j-1], mag_ff[j-1][IW-1-j*DW -: DW],
                                      cfg.extent);
      end

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            ix_ff[j]  <= ix_in[j];
            mag_ff[j] <= mag_in[j];
            rem_ff[j] <= rem_in[j];
         end
      end
   end

   logic [EW-1:0]          wrapped;
   logic [IW-1:0]          val;
   logic                   bad;
   rnag_pkg::lane_res_type res_ff;
   rnag_pkg::lane_res_type res_in;

   // true modulo, pick wrapped or raw index, range check; an unused lane gives zero of extent one
   always_comb begin
      wrapped = rem_ff[NM-1];
      if (ix_ff[NM-1][IW-1] && (rem_ff[NM-1] != '0)) begin
         wrapped = cfg.extent - rem_ff[NM-1];
      end
      val = cfg.torus ? IW'(wrapped) : ix_ff[NM-1];
      bad = val[IW-1] || (val >= IW'(cfg.extent));
      if (cfg.used) begin
         res_in.val    = val;
         res_in.extent = cfg.extent;
         res_in.bad    = bad;
      end else begin
         res_in.val    = '0;
         res_in.extent = EW'(1);
         res_in.bad    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[NM]) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rnag_merge.sv
`default_nettype none

module rnag_merge #(
   parameter int LANES = rnag_pkg::FIELD_DIMS
) (
   input  wire logic                                  clock,
   input  wire logic [2*LANES-1:0]                    stage_en,
   input  wire logic [rnag_pkg::ELEM_W-1:0]           elem_bytes,
   input  wire logic                                  bound_check,
   input  wire rnag_pkg::lane_res_type [LANES-1:0]    lane_res,
   output logic [rnag_pkg::OFFSET_W-1:0]              byte_offset,
   output logic                                       out_of_range
);

   localparam int OW = rnag_pkg::OFFSET_W;
   localparam int HW = rnag_pkg::HALF_W;
   localparam int PW = rnag_pkg::PROD_W;
   localparam int IW = rnag_pkg::INDEX_W;
   localparam int EW = rnag_pkg::EXT_W;

   // stage a: partial products, stage b: recombine and add next index
   logic [OW-1:0]                          acc_src    [LANES];
   logic                                   bad_src    [LANES];
   rnag_pkg::lane_res_type [LANES-1:0]     lanes_src  [LANES];
   logic [EW-1:0]                          mul_op     [LANES];
   logic [OW-1:0]                          addend     [LANES];

   logic [PW-1:0]                          pl_ff      [LANES];
   logic [PW-1:0]                          ph_ff      [LANES];
   logic [OW-1:0]                          add_ff     [LANES];
   logic                                   bad_a_ff   [LANES];
   rnag_pkg::lane_res_type [LANES-1:0]     lanes_a_ff [LANES];

   logic [OW-1:0]                          sum        [LANES];
   logic [OW-1:0]                          acc_in     [LANES];
   logic [OW-1:0]                          acc_ff     [LANES];
   logic                                   bad_b_ff   [LANES];
   rnag_pkg::lane_res_type [LANES-1:0]     lanes_b_ff [LANES];

   logic                                   any_bad;

   // any lane out of range
   always_comb begin
      any_bad = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         any_bad = any_bad | lane_res[k].bad;
      end
   end

   for (genvar m = 0; m < LANES; m++) begin : g_step
      // source of this step: lane outputs or previous step
      if (m == 0) begin : g_src_first
         assign acc_src[m]   = {{(OW-IW){lane_res[0].val[IW-1]}}, lane_res[0].val};
         assign bad_src[m]   = any_bad;
         assign lanes_src[m] = lane_res;
      end else begin : g_src_next
         assign acc_src[m]   = acc_ff[m-1];
         assign bad_src[m]   = bad_b_ff[m-1];
         assign lanes_src[m] = lanes_b_ff[m-1];
      end

      // horner step for the next dimension, then the element size
      if (m < LANES - 1) begin : g_dim
         assign mul_op[m] = lanes_src[m][m+1].extent;
         assign addend[m] = {{(OW-IW){lanes_src[m][m+1].val[IW-1]}},
                             lanes_src[m][m+1].val};
      end else begin : g_elem
         assign mul_op[m] = EW'(elem_bytes);
         assign addend[m] = '0;
      end

      always_ff @(posedge clock) begin
         if (stage_en[2*m]) begin
            pl_ff[m]      <= PW'(acc_src[m][HW-1:0]) * PW'(mul_op[m]);
            ph_ff[m]      <= PW'(acc_src[m][OW-1:HW]) * PW'(mul_op[m]);
            add_ff[m]     <= addend[m];
            bad_a_ff[m]   <= bad_src[m];
            lanes_a_ff[m] <= lanes_src[m];
         end
      end

      assign sum[m] = {ph_ff[m][OW-HW-1:0], {HW{1'b0}}} + OW'(pl_ff[m]) + add_ff[m];

      // rejected requests give a zero offset
      if (m == LANES - 1) begin : g_last
         assign acc_in[m] = (bound_check && bad_a_ff[m]) ? '0 : sum[m];
      end else begin : g_mid
         assign acc_in[m] = sum[m];
      end

      always_ff @(posedge clock) begin
         if (stage_en[2*m+1]) begin
            acc_ff[m]     <= acc_in[m];
            bad_b_ff[m]   <= bad_a_ff[m];
            lanes_b_ff[m] <= lanes_a_ff[m];
         end
      end
   end

   assign byte_offset  = acc_ff[LANES-1];
   assign out_of_range = bad_b_ff[LANES-1];

endmodule

`default_nettype wire

FILE: hw/rtl/row_major_nd_address_generator.sv
// Row-major n-dimensional address generator with optional torus wrap.
// Request channel (req_valid/req_ready) carries one signed index per
// dimension, outermost first; response channel (rsp_valid/rsp_ready)
// returns the byte offset of that element and an out-of-range flag.
// Registers on the APB-style port set dimension count, extents, element
// size and the torus and bound-check modes; write them only while no
// transfer is in flight. pready is always high, reads return the values.
// Throughput: one transfer per cycle until receiver stalls fill the
// pipeline. An item passes four remainder stages of four dividend bits
// each, the first loaded at the transfer edge, one wrap and range stage,
// and a multiply and an add stage for each inner dimension and for the
// element size. Lanes are min(MAX_DIMS, 4).
// Reset clears the pipeline and loads register defaults: one dimension,
// all extents 1, element size 1, both modes off.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling empty slots; req_ready drops only once
// every stage holds an item.
`default_nettype none

module row_major_nd_address_generator #(
   parameter int MAX_DIMS = rnag_pkg::MAX_DIMS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [rnag_pkg::INDEX_W-1:0]          req_index_0,
   input  wire logic [rnag_pkg::INDEX_W-1:0]          req_index_1,
   input  wire logic [rnag_pkg::INDEX_W-1:0]          req_index_2,
   input  wire logic [rnag_pkg::INDEX_W-1:0]          req_index_3,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [rnag_pkg::OFFSET_W-1:0]              rsp_byte_offset,
   output logic                                       rsp_out_of_range,
   // register port
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [rnag_pkg::ADDR_W-1:0]           paddr,
   input  wire logic [rnag_pkg::DATA_W-1:0]           pwdata,
   output logic [rnag_pkg::DATA_W-1:0]                prdata,
   output logic                                       pready
);

   localparam int FD    = rnag_pkg::FIELD_DIMS;
   localparam int LANES = (MAX_DIMS < FD) ? MAX_DIMS : FD;
   localparam int NL    = rnag_pkg::LANE_STAGES;
   localparam int NS    = NL + 2 * LANES;
   localparam int EW    = rnag_pkg::EXT_W;
   localparam int CW    = rnag_pkg::DIM_COUNT_W;
   localparam int BW    = rnag_pkg::ELEM_W;
   localparam int AW    = rnag_pkg::ADDR_W;

   // configuration registers
   logic [CW-1:0] dim_count_ff;
   logic [EW-1:0] size_ff [FD];
   logic [BW-1:0] elem_bytes_ff;
   logic          torus_mode_ff;
   logic          bound_check_ff;

   logic                    csr_write;
   rnag_pkg::reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = rnag_pkg::reg_index_type'(paddr[AW-1:2]);

   // register write on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff   <= CW'(1);
         for (int k = 0; k < FD; k++) begin
            size_ff[k] <= EW'(1);
         end
         elem_bytes_ff  <= BW'(1);
         torus_mode_ff  <= 1'b0;
         bound_check_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            rnag_pkg::REG_DIM_COUNT:   dim_count_ff   <= pwdata[CW-1:0];
            rnag_pkg::REG_SIZE_DIM0:   size_ff[0]     <= pwdata[EW-1:0];
            rnag_pkg::REG_SIZE_DIM1:   size_ff[1]     <= pwdata[EW-1:0];
            rnag_pkg::REG_SIZE_DIM2:   size_ff[2]     <= pwdata[EW-1:0];
            rnag_pkg::REG_SIZE_DIM3:   size_ff[3]     <= pwdata[EW-1:0];
            rnag_pkg::REG_ELEM_BYTES:  elem_bytes_ff  <= pwdata[BW-1:0];
            rnag_pkg::REG_TORUS_MODE:  torus_mode_ff  <= pwdata[0];
            rnag_pkg::REG_BOUND_CHECK: bound_check_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      prdata = '0;
      unique case (csr_index)
         rnag_pkg::REG_DIM_COUNT:   prdata[CW-1:0] = dim_count_ff;
         rnag_pkg::REG_SIZE_DIM0:   prdata[EW-1:0] = size_ff[0];
         rnag_pkg::REG_SIZE_DIM1:   prdata[EW-1:0] = size_ff[1];
         rnag_pkg::REG_SIZE_DIM2:   prdata[EW-1:0] = size_ff[2];
         rnag_pkg::REG_SIZE_DIM3:   prdata[EW-1:0] = size_ff[3];
         rnag_pkg::REG_ELEM_BYTES:  prdata[BW-1:0] = elem_bytes_ff;
         rnag_pkg::REG_TORUS_MODE:  prdata[0]      = torus_mode_ff;
         rnag_pkg::REG_BOUND_CHECK: prdata[0]      = bound_check_ff;
         default:                   prdata         = '0;
      endcase
   end

   // pipeline occupancy: a stage loads when it is empty or its successor loads
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS:0]   stage_en;

   always_comb begin
      stage_en[NS] = rsp_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      for (int i = 0; i < NS; i++) begin
         if (!stage_en[i]) begin
            valid_in[i] = valid_ff[i];
         end else if (i == 0) begin
            valid_in[i] = req_valid;
         end else begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[NS-1];

   // index lanes
   logic [rnag_pkg::INDEX_W-1:0]       req_index [FD];
   rnag_pkg::lane_cfg_type             lane_cfg  [LANES];
   rnag_pkg::lane_res_type [LANES-1:0] lane_res;

   assign req_index[0] = req_index_0;
   assign req_index[1] = req_index_1;
   assign req_index[2] = req_index_2;
   assign req_index[3] = req_index_3;

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      // dimension in use, an extent of zero acts as one
      always_comb begin
         lane_cfg[k].used   = (k == 0) || (dim_count_ff > CW'(k));
         lane_cfg[k].torus  = torus_mode_ff;
         lane_cfg[k].extent = (!lane_cfg[k].used || (size_ff[k] == '0)) ?
                              EW'(1) : size_ff[k];
      end

      rnag_lane u_lane (
         .clock    (clock),
         .stage_en (stage_en[NL-1:0]),
         .cfg      (lane_cfg[k]),
         .index    (req_index[k]),
         .res      (lane_res[k])
      );
   end

   // horner combine and element scaling
   rnag_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock        (clock),
      .stage_en     (stage_en[NS-1:NL]),
      .elem_bytes   (elem_bytes_ff),
      .bound_check  (bound_check_ff),
      .lane_res     (lane_res),
      .byte_offset  (rsp_byte_offset),
      .out_of_range (rsp_out_of_range)
   );

endmodule

`default_nettype wire

FILE: bench/rnag_checker.sv
`timescale 1ns / 100ps

module rnag_checker #(
   parameter int MAX_DIMS = rnag_pkg::MAX_DIMS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [rnag_pkg::INDEX_W-1:0]   req_index_0,
   input  wire logic [rnag_pkg::INDEX_W-1:0]   req_index_1,
   input  wire logic [rnag_pkg::INDEX_W-1:0]   req_index_2,
   input  wire logic [rnag_pkg::INDEX_W-1:0]   req_index_3,
   // response channel
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic [rnag_pkg::OFFSET_W-1:0]  rsp_byte_offset,
   input  wire logic                           rsp_out_of_range,
   // register port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic                           pready,
   input  wire logic [rnag_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [rnag_pkg::DATA_W-1:0]    pwdata,
   // status for the bench top
   output int                                  outstanding,
   output int                                  fail_count
);

   typedef struct packed {
      logic [rnag_pkg::OFFSET_W-1:0] byte_offset;
      logic                          out_of_range;
   } element_addr_type;

   // local copy of the register file, tracked from observed writes
   logic [rnag_pkg::DIM_COUNT_W-1:0] dims_reg;
   logic [rnag_pkg::EXT_W-1:0]       extent_reg [rnag_pkg::FIELD_DIMS];
   logic [rnag_pkg::ELEM_W-1:0]      elem_reg;
   logic                             torus_on;
   logic                             bound_on;

   element_addr_type expected_addrs [$];
   int               errors = 0;

   initial begin
      outstanding = 0;
      fail_count  = 0;
   end

   // row-major offset of one index tuple under the current settings
   function automatic element_addr_type locate_element(
      input logic [rnag_pkg::FIELD_DIMS-1:0][rnag_pkg::INDEX_W-1:0] idx
   );
      element_addr_type res;
      int               used;
      int               ext;
      int               ix;
      int               k;
      logic [63:0]      acc;
      logic [63:0]      ext_w;
      logic [63:0]      ix_w;
      logic             bad;
      used = int'(dims_reg);
      if (used < 1) used = 1;
      if (used > MAX_DIMS) used = MAX_DIMS;
      if (used > rnag_pkg::FIELD_DIMS) used = rnag_pkg::FIELD_DIMS;
      acc = '0;
      bad = 1'b0;
      for (k = 0; k < used; k++) begin
         // a zero extent behaves as one
         ext = (extent_reg[k] == '0) ? 1 : int'(extent_reg[k]);
         ix  = int'($signed(idx[k]));
         // true modulo: remainder brought into 0..ext-1
         if (torus_on) begin
            ix = ix % ext;
            if (ix < 0) ix = ix + ext;
         end
         if (ix < 0 || ix >= ext) bad = 1'b1;
         ext_w = 64'(ext);
         ix_w  = 64'(ix);
         acc   = acc * ext_w + ix_w;
      end
      acc = acc * 64'(elem_reg);
      res.byte_offset  = (bound_on && bad) ? '0 : acc[rnag_pkg::OFFSET_W-1:0];
      res.out_of_range = bad;
      return res;
   endfunction

   always @(posedge clock) begin
      element_addr_type due;
      if (reset) begin
         dims_reg = rnag_pkg::DIM_COUNT_W'(1);
         for (int k = 0; k < rnag_pkg::FIELD_DIMS; k++)
            extent_reg[k] = rnag_pkg::EXT_W'(1);
         elem_reg = rnag_pkg::ELEM_W'(1);
         torus_on = 1'b0;
         bound_on = 1'b0;
         expected_addrs.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (rnag_pkg::reg_index_type'(paddr[4:2]))
               rnag_pkg::REG_DIM_COUNT:
                  dims_reg      = pwdata[rnag_pkg::DIM_COUNT_W-1:0];
               rnag_pkg::REG_SIZE_DIM0:   extent_reg[0] = pwdata[rnag_pkg::EXT_W-1:0];
               rnag_pkg::REG_SIZE_DIM1:   extent_reg[1] = pwdata[rnag_pkg::EXT_W-1:0];
               rnag_pkg::REG_SIZE_DIM2:   extent_reg[2] = pwdata[rnag_pkg::EXT_W-1:0];
               rnag_pkg::REG_SIZE_DIM3:   extent_reg[3] = pwdata[rnag_pkg::EXT_W-1:0];
               rnag_pkg::REG_ELEM_BYTES:  elem_reg      = pwdata[rnag_pkg::ELEM_W-1:0];
               rnag_pkg::REG_TORUS_MODE:  torus_on      = pwdata[0];
               rnag_pkg::REG_BOUND_CHECK: bound_on      = pwdata[0];
               default: ;
            endcase
         end
         // request transfer
         if (req_valid && req_ready)
            expected_addrs.push_back(locate_element(
               {req_index_3, req_index_2, req_index_1, req_index_0}));
         // response transfer
         if (rsp_valid && rsp_ready) begin
            if (expected_addrs.size() == 0) begin
               errors++;
               $error("response transfer with no request outstanding");
            end else begin
               due = expected_addrs.pop_front();
               if (rsp_byte_offset !== due.byte_offset) begin
                  errors++;
                  $error("byte_offset: expected %0h, actual %0h",
                         due.byte_offset, rsp_byte_offset);
               end
               if (rsp_out_of_range !== due.out_of_range) begin
                  errors++;
                  $error("out_of_range: expected %0b, actual %0b",
                         due.out_of_range, rsp_out_of_range);
               end
            end
         end
      end
      outstanding <= expected_addrs.size();
      fail_count  <= errors;
   end

endmodule

FILE: bench/row_major_nd_address_generator_test.sv
`timescale 1ns / 100ps

module row_major_nd_address_generator_test;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [rnag_pkg::INDEX_W-1:0]  req_index_0;
   logic [rnag_pkg::INDEX_W-1:0]  req_index_1;
   logic [rnag_pkg::INDEX_W-1:0]  req_index_2;
   logic [rnag_pkg::INDEX_W-1:0]  req_index_3;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [rnag_pkg::OFFSET_W-1:0] rsp_byte_offset;
   logic                          rsp_out_of_range;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [rnag_pkg::ADDR_W-1:0]   paddr;
   logic [rnag_pkg::DATA_W-1:0]   pwdata;
   logic [rnag_pkg::DATA_W-1:0]   prdata;
   logic                          pready;
   int                            outstanding;
   int                            fail_count;

   // idle odds in percent per cycle, and requests for a long response hold-off
   int unsigned req_idle_pct = 8;
   int unsigned rsp_idle_pct = 57;
   int          hold_asks    = 0;

   // effective extents, used only to shape the stimulus
   int unsigned ext_now [rnag_pkg::FIELD_DIMS] = '{1, 1, 1, 1};

   row_major_nd_address_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_index_0      (req_index_0),
      .req_index_1      (req_index_1),
      .req_index_2      (req_index_2),
      .req_index_3      (req_index_3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_out_of_range (rsp_out_of_range),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   rnag_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_index_0      (req_index_0),
      .req_index_1      (req_index_1),
      .req_index_2      (req_index_2),
      .req_index_3      (req_index_3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_out_of_range (rsp_out_of_range),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .pready           (pready),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .outstanding      (outstanding),
      .fail_count       (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #2000000;
      $display("row_major_nd_address_generator: mismatch");
      $finish;
   end

   // response side: random back-pressure plus requested long hold-offs
   initial begin
      int stall_left;
      int asks_seen;
      stall_left = 0;
      asks_seen  = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != asks_seen) begin
            asks_seen  = hold_asks;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // one register write: setup cycle, then access cycle
   task automatic write_reg(input rnag_pkg::reg_index_type r,
                            input logic [rnag_pkg::DATA_W-1:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // hold off requests until every response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic apply_settings(input int unsigned dims, e0, e1, e2, e3, eb,
                                 input int unsigned torus, bound);
      wait_drained();
      write_reg(rnag_pkg::REG_DIM_COUNT, dims);
      write_reg(rnag_pkg::REG_SIZE_DIM0, e0);
      write_reg(rnag_pkg::REG_SIZE_DIM1, e1);
      write_reg(rnag_pkg::REG_SIZE_DIM2, e2);
      write_reg(rnag_pkg::REG_SIZE_DIM3, e3);
      write_reg(rnag_pkg::REG_ELEM_BYTES, eb);
      write_reg(rnag_pkg::REG_TORUS_MODE, torus);
      write_reg(rnag_pkg::REG_BOUND_CHECK, bound);
      ext_now[0] = (e0 == 0) ? 1 : e0;
      ext_now[1] = (e1 == 0) ? 1 : e1;
      ext_now[2] = (e2 == 0) ? 1 : e2;
      ext_now[3] = (e3 == 0) ? 1 : e3;
   endtask

   // random settings leaning toward small extents, with edge extents and dimension counts past four
   task automatic pick_settings();
      int unsigned ext [rnag_pkg::FIELD_DIMS];
      int unsigned dims;
      int unsigned eb;
      int unsigned roll;
      int          k;
      roll = $urandom_range(0, 99);
      dims = (roll < 75) ? $urandom_range(1, 4) : $urandom_range(0, 7);
      for (k = 0; k < rnag_pkg::FIELD_DIMS; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 50) ext[k] = $urandom_range(1, 16);
         else if (roll < 65) begin
            case ($urandom_range(0, 3))
               0: ext[k] = 0;
               1: ext[k] = 1;
               2: ext[k] = 4096;
               default: ext[k] = 8191;
            endcase
         end
         else if (roll < 85) ext[k] = $urandom_range(1, 4096);
         else ext[k] = $urandom_range(0, 8191);
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) eb = $urandom_range(1, 256);
      else if (roll < 70) eb = 0;
      else if (roll < 80) eb = 511;
      else eb = $urandom_range(0, 511);
      apply_settings(dims, ext[0], ext[1], ext[2], ext[3], eb,
                     $urandom_range(0, 1), $urandom_range(0, 1));
   endtask

   // mostly in range, with edges just outside and full-range noise
   function automatic int pick_index(input int unsigned ext);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return int'($urandom_range(0, ext - 1));
      if (roll < 68) return -1;
      if (roll < 76) return int'(ext);
      return int'($urandom_range(0, 65535));
   endfunction

   // offer one index tuple and wait for its transfer
   task automatic offer_indices(input int i0, i1, i2, i3);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_index_0 <= 16'(i0);
      req_index_1 <= 16'(i1);
      req_index_2 <= 16'(i2);
      req_index_3 <= 16'(i3);
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int p;
      int n;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_index_0 <= '0;
      req_index_1 <= '0;
      req_index_2 <= '0;
      req_index_3 <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults after reset: one dimension of extent one
      offer_indices(0, 0, 0, 0);
      offer_indices(-1, 5, 5, 5);
      offer_indices(32767, -32768, 0, 0);

      // largest regular extents and element size, no modes
      apply_settings(4, 4096, 4096, 4096, 4096, 256, 0, 0);
      offer_indices(4095, 4095, 4095, 4095);
      offer_indices(-32768, -32768, -32768, -32768);
      offer_indices(32767, 32767, 32767, 32767);
      offer_indices(0, 0, 0, 1);

      // torus wrap of negative and oversized indices
      apply_settings(3, 5, 6, 7, 9, 3, 1, 0);
      offer_indices(-1, -7, 13, 0);
      offer_indices(-32768, 32767, -5, 100);

      // bound check with a zero extent
      apply_settings(2, 10, 0, 1, 1, 4, 0, 1);
      offer_indices(9, 0, 0, 0);
      offer_indices(10, 0, 0, 0);
      offer_indices(-1, 0, 0, 0);
      offer_indices(3, 1, 0, 0);

      // both modes, dimension count saturated, extent past 4096, zero element size
      apply_settings(7, 8191, 3, 2, 5, 0, 1, 1);
      offer_indices(8190, -1, -3, 77);
      offer_indices(-32768, 32767, 1, -1);

      // zero dimension count acts as one
      apply_settings(0, 100, 2, 2, 2, 17, 0, 0);
      offer_indices(99, -1, -1, -1);
      offer_indices(100, 5, 5, 5);

      // both modes with the widest element size
      apply_settings(4, 3, 3, 3, 3, 511, 1, 1);
      offer_indices(-4, 4, -32768, 32767);

      // random phases
      for (p = 0; p < 10; p++) begin
         if (p < 4) begin
            req_idle_pct = 8;
            rsp_idle_pct = 57;
         end else if (p < 7) begin
            req_idle_pct = 57;
            rsp_idle_pct = 8;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         pick_settings();
         // long response hold-off so the pipeline fills and stalls requests
         if (p == 2 || p == 8) hold_asks++;
         for (n = 0; n < 70; n++) begin
            if (p == 5 && n == 35) wait_drained();
            offer_indices(pick_index(ext_now[0]), pick_index(ext_now[1]),
                          pick_index(ext_now[2]), pick_index(ext_now[3]));
         end
      end

      // drain, then give stray responses time to show
      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("row_major_nd_address_generator: match");
      else
         $display("row_major_nd_address_generator: mismatch");
      $finish;
   end

endmodule
